// ===== design/iss_pkg.sv =====
// Shared types and codes for the integer set store.
// Holds the request and response transaction structs, opcodes, sequencer states
// and the control and status structs between the sequencer and the compare unit. No dependencies.
`default_nettype none

package iss_pkg;

	localparam int DATA_W = 32;
	localparam int WORD_W = DATA_W + 1;
	localparam int SIZE_W = 5;

	typedef enum logic [2:0] {
		OP_CLEAR     = 3'd0,
		OP_INSERT    = 3'd1,
		OP_REMOVE    = 3'd2,
		OP_CONTAINS  = 3'd3,
		OP_UNION     = 3'd4,
		OP_INTERSECT = 3'd5,
		OP_DIFF      = 3'd6,
		OP_NOP       = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_SCAN,
		ST_EVAL,
		ST_SRC_RD,
		ST_SRC_CHK,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]               opcode;
		logic [2:0]               dest_set;
		logic [2:0]               src_a;
		logic [2:0]               src_b;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic              found;
		logic              status;
		logic [SIZE_W-1:0] set_size;
	} rsp_t;

	typedef struct packed {
		logic clr;
		logic take;
	} match_ctl_t;

	typedef struct packed {
		logic hit;
		logic free;
	} match_stat_t;

endpackage

`default_nettype wire

// ===== design/iss_mem.sv =====
// Member storage: one word per slot, valid bit on top of the 32-bit value.
// One write port and one read port with registered read data. Uses iss_pkg.
`default_nettype none

module iss_mem #(
	parameter int ADDR_W = 7
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [ADDR_W-1:0]          waddr,
	input  wire logic [iss_pkg::WORD_W-1:0] wdata,
	input  wire logic                       re,
	input  wire logic [ADDR_W-1:0]          raddr,
	output logic      [iss_pkg::WORD_W-1:0] rdata
);

	logic [iss_pkg::WORD_W-1:0] mem_q [2**ADDR_W];
	logic [iss_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/iss_match.sv =====
// Shared compare unit: compares each scanned slot against the key and gathers
// hit, first free slot and member count over a scan. Uses iss_pkg.
`default_nettype none

module iss_match #(
	parameter int SLOT_W = 4,
	parameter int CNT_W  = 5
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire iss_pkg::match_ctl_t        ctl,
	input  wire logic [SLOT_W-1:0]          slot,
	input  wire logic [iss_pkg::DATA_W-1:0] key,
	input  wire logic [iss_pkg::WORD_W-1:0] word,
	output logic                            match,
	output iss_pkg::match_stat_t            stat,
	output logic [SLOT_W-1:0]               free_slot,
	output logic [CNT_W-1:0]                count
);

	logic              hit_q;
	logic              free_q;
	logic [SLOT_W-1:0] free_slot_q;
	logic [CNT_W-1:0]  count_q;
	logic              word_valid;

	assign word_valid = word[iss_pkg::WORD_W-1];
	assign match      = word_valid && (word[iss_pkg::DATA_W-1:0] == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			count_q <= '0;
		end else if (ctl.clr) begin
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			count_q <= '0;
		end else if (ctl.take) begin
			if (match) begin
				hit_q <= 1'b1;
			end
			if (!word_valid) begin
				free_q <= 1'b1;
			end
			if (word_valid) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// The lowest empty slot wins, so only the first one seen in a scan is kept.
	always_ff @(posedge clk) begin
		if (ctl.take && !word_valid && !free_q) begin
			free_slot_q <= slot;
		end
	end

	assign stat      = '{hit: hit_q, free: free_q};
	assign free_slot = free_slot_q;
	assign count     = count_q;

endmodule

`default_nettype wire

// ===== design/iss_seq.sv =====
// Sequencer of the integer set store: walks the slots of the sets, drives the
// member memory and the shared compare unit, and builds the result. Uses iss_pkg.
`default_nettype none

module iss_seq #(
	parameter int NUM_SETS     = 8,
	parameter int SET_CAPACITY = 16,
	localparam int SET_W       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
	localparam int SLOT_W      = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1,
	localparam int CNT_W       = $clog2(SET_CAPACITY + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire iss_pkg::req_t              req,
	output logic                            idle,
	output logic                            res_valid,
	output iss_pkg::rsp_t                   res,
	input  wire logic                       res_take,
	output logic                            mem_we,
	output logic [SET_W+SLOT_W-1:0]         mem_waddr,
	output logic [iss_pkg::WORD_W-1:0]      mem_wdata,
	output logic                            mem_re,
	output logic [SET_W+SLOT_W-1:0]         mem_raddr,
	input  wire logic [iss_pkg::WORD_W-1:0] mem_rdata,
	output iss_pkg::match_ctl_t             mctl,
	output logic [SLOT_W-1:0]               mslot,
	output logic [iss_pkg::DATA_W-1:0]      mkey,
	input  wire logic                       mmatch,
	input  wire iss_pkg::match_stat_t       mstat,
	input  wire logic [SLOT_W-1:0]          mfree_slot,
	input  wire logic [CNT_W-1:0]           mcount
);

	localparam int ADDR_W = SET_W + SLOT_W;

	iss_pkg::state_t          state_q;
	iss_pkg::state_t          state_d;
	iss_pkg::op_t             op_q;
	logic [ADDR_W-1:0]        init_q;
	logic [CNT_W-1:0]         j_q;
	logic [SLOT_W-1:0]        i_q;
	logic                     pend_q;
	logic [SLOT_W-1:0]        pend_slot_q;
	logic                     phase_b_q;
	logic                     test_q;
	logic [SET_W-1:0]         dest_q;
	logic [SET_W-1:0]         srca_q;
	logic [SET_W-1:0]         srcb_q;
	logic [SET_W-1:0]         src_q;
	logic [SET_W-1:0]         scan_set_q;
	logic                     a_ok_q;
	logic                     b_ok_q;
	logic [iss_pkg::DATA_W-1:0] key_q;
	logic                     found_q;
	logic                     full_q;
	logic [CNT_W-1:0]         size_q;

	logic dest_ok;
	logic setop;
	logic scan_issue;
	logic clr_last;
	logic src_last;
	logic take_b;
	logic ins_need;
	logic ins_ok;
	logic rd_valid;
	logic start_setop;
	logic start_clr;

	assign dest_ok     = int'(req.dest_set) < NUM_SETS;
	assign setop       = (op_q == iss_pkg::OP_UNION) || (op_q == iss_pkg::OP_INTERSECT) ||
	                     (op_q == iss_pkg::OP_DIFF);
	assign start_setop = (req.opcode == iss_pkg::OP_UNION) ||
	                     (req.opcode == iss_pkg::OP_INTERSECT) ||
	                     (req.opcode == iss_pkg::OP_DIFF);
	assign start_clr   = (req.opcode == iss_pkg::OP_CLEAR) || start_setop;
	assign scan_issue  = j_q != CNT_W'(SET_CAPACITY);
	assign clr_last    = j_q == CNT_W'(SET_CAPACITY - 1);
	assign src_last    = i_q == SLOT_W'(SET_CAPACITY - 1);
	assign take_b      = (op_q == iss_pkg::OP_INTERSECT) ? mstat.hit : !mstat.hit;
	assign ins_need    = (op_q == iss_pkg::OP_INSERT) || (setop && !test_q);
	assign ins_ok      = ins_need && !mstat.hit && mstat.free;
	assign rd_valid    = mem_rdata[iss_pkg::WORD_W-1];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			iss_pkg::ST_INIT: begin
				if (init_q == '1) begin
					state_d = iss_pkg::ST_IDLE;
				end
			end
			iss_pkg::ST_IDLE: begin
				if (start) begin
					if (!dest_ok) begin
						state_d = iss_pkg::ST_DONE;
					end else if (start_clr) begin
						state_d = iss_pkg::ST_CLR;
					end else begin
						state_d = iss_pkg::ST_SCAN;
					end
				end
			end
			iss_pkg::ST_CLR: begin
				if (clr_last) begin
					if (op_q == iss_pkg::OP_CLEAR) begin
						state_d = iss_pkg::ST_DONE;
					end else if (a_ok_q || (op_q == iss_pkg::OP_UNION && b_ok_q)) begin
						state_d = iss_pkg::ST_SRC_RD;
					end else begin
						state_d = iss_pkg::ST_DONE;
					end
				end
			end
			iss_pkg::ST_SCAN: begin
				if (!scan_issue) begin
					state_d = iss_pkg::ST_EVAL;
				end
			end
			iss_pkg::ST_EVAL: begin
				if (!setop) begin
					state_d = iss_pkg::ST_DONE;
				end else if (test_q && take_b) begin
					state_d = iss_pkg::ST_SCAN;
				end else begin
					state_d = iss_pkg::ST_NEXT;
				end
			end
			iss_pkg::ST_SRC_RD: begin
				state_d = iss_pkg::ST_SRC_CHK;
			end
			iss_pkg::ST_SRC_CHK: begin
				if (!rd_valid || (op_q == iss_pkg::OP_INTERSECT && !b_ok_q)) begin
					state_d = iss_pkg::ST_NEXT;
				end else begin
					state_d = iss_pkg::ST_SCAN;
				end
			end
			iss_pkg::ST_NEXT: begin
				if (!src_last) begin
					state_d = iss_pkg::ST_SRC_RD;
				end else if (!phase_b_q && op_q == iss_pkg::OP_UNION && b_ok_q) begin
					state_d = iss_pkg::ST_SRC_RD;
				end else begin
					state_d = iss_pkg::ST_DONE;
				end
			end
			iss_pkg::ST_DONE: begin
				if (res_take) begin
					state_d = iss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = iss_pkg::ST_IDLE;
			end
		endcase
	end

	// Memory and compare unit control.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			iss_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = init_q;
			end
			iss_pkg::ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = {dest_q, j_q[SLOT_W-1:0]};
			end
			iss_pkg::ST_SCAN: begin
				mem_re    = scan_issue;
				mem_raddr = {scan_set_q, j_q[SLOT_W-1:0]};
				if (op_q == iss_pkg::OP_REMOVE && pend_q && mmatch) begin
					mem_we    = 1'b1;
					mem_waddr = {scan_set_q, pend_slot_q};
				end
			end
			iss_pkg::ST_EVAL: begin
				if (ins_ok) begin
					mem_we    = 1'b1;
					mem_waddr = {dest_q, mfree_slot};
					mem_wdata = {1'b1, key_q};
				end
			end
			iss_pkg::ST_SRC_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {src_q, i_q};
			end
			default: begin
			end
		endcase
	end

	assign mctl      = '{clr: state_q != iss_pkg::ST_SCAN,
	                     take: (state_q == iss_pkg::ST_SCAN) && pend_q};
	assign mslot     = pend_slot_q;
	assign mkey      = key_q;
	assign idle      = state_q == iss_pkg::ST_IDLE;
	assign res_valid = state_q == iss_pkg::ST_DONE;
	assign res       = '{found: found_q, status: full_q, set_size: iss_pkg::SIZE_W'(size_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= iss_pkg::ST_INIT;
			init_q    <= '0;
			j_q       <= '0;
			i_q       <= '0;
			pend_q    <= 1'b0;
			phase_b_q <= 1'b0;
			test_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= (state_q == iss_pkg::ST_SCAN) && scan_issue;
			if (state_q == iss_pkg::ST_INIT) begin
				init_q <= init_q + ADDR_W'(1);
			end
			if (state_q == iss_pkg::ST_CLR ||
			    (state_q == iss_pkg::ST_SCAN && scan_issue)) begin
				j_q <= j_q + CNT_W'(1);
			end else begin
				j_q <= '0;
			end
			case (state_q)
				iss_pkg::ST_CLR: begin
					phase_b_q <= !a_ok_q;
					i_q       <= '0;
				end
				iss_pkg::ST_SRC_CHK: begin
					test_q <= (op_q != iss_pkg::OP_UNION) && b_ok_q;
				end
				iss_pkg::ST_EVAL: begin
					test_q <= 1'b0;
				end
				iss_pkg::ST_NEXT: begin
					if (!src_last) begin
						i_q <= i_q + SLOT_W'(1);
					end else begin
						phase_b_q <= 1'b1;
						i_q       <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == iss_pkg::ST_SCAN) begin
			pend_slot_q <= j_q[SLOT_W-1:0];
		end
		case (state_q)
			iss_pkg::ST_IDLE: begin
				if (start) begin
					op_q       <= iss_pkg::op_t'(req.opcode);
					dest_q     <= SET_W'(req.dest_set);
					srca_q     <= SET_W'(req.src_a);
					srcb_q     <= SET_W'(req.src_b);
					scan_set_q <= SET_W'(req.dest_set);
					a_ok_q     <= int'(req.src_a) < NUM_SETS;
					b_ok_q     <= int'(req.src_b) < NUM_SETS;
					key_q      <= req.value;
					found_q    <= 1'b0;
					full_q     <= 1'b0;
					size_q     <= '0;
				end
			end
			iss_pkg::ST_CLR: begin
				src_q <= a_ok_q ? srca_q : srcb_q;
			end
			iss_pkg::ST_SRC_CHK: begin
				key_q      <= mem_rdata[iss_pkg::DATA_W-1:0];
				scan_set_q <= ((op_q != iss_pkg::OP_UNION) && b_ok_q) ? srcb_q : dest_q;
			end
			iss_pkg::ST_EVAL: begin
				if (!setop || !test_q) begin
					if (ins_ok) begin
						size_q <= mcount + CNT_W'(1);
					end else if (op_q == iss_pkg::OP_REMOVE && mstat.hit) begin
						size_q <= mcount - CNT_W'(1);
					end else begin
						size_q <= mcount;
					end
					if (ins_need && !mstat.hit && !mstat.free) begin
						full_q <= 1'b1;
					end
				end
				if (op_q == iss_pkg::OP_INSERT || op_q == iss_pkg::OP_REMOVE ||
				    op_q == iss_pkg::OP_CONTAINS) begin
					found_q <= mstat.hit;
				end
				if (setop && test_q) begin
					scan_set_q <= dest_q;
				end
			end
			iss_pkg::ST_NEXT: begin
				if (src_last) begin
					src_q <= srcb_q;
				end
			end
			default: begin
			end
		endcase
	end

	// A remove clears the slot behind the one being read, never the same word.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("iss_seq: read and write to the same slot in one cycle");

endmodule

`default_nettype wire

// ===== design/integer_set_store.sv =====
// Top level of the integer set store: sequencer, shared compare unit, member
// memory and the response register. Uses iss_pkg, iss_mem, iss_match and iss_seq.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  req     | in        | req_valid/req_ready | iss_pkg::req_t: opcode, sets, value
//  rsp     | out       | rsp_valid/rsp_ready | iss_pkg::rsp_t: found, status, size
//
// After reset the block sweeps all 2**(clog2(NUM_SETS) + clog2(SET_CAPACITY)) words
// (128 by default) to empty, one word a cycle; req_ready stays low meanwhile. One
// request transaction is worked on at a time, and every step goes through the single
// memory read port and the one compare unit behind it.
// Insert, remove, contains: one scan of the set before the result.
// Clear: every slot of the destination set is written empty. Set operations: clear the
// destination, then read each source slot in turn; every member found is inserted
// with a scan of the destination and, for intersection and difference, is first looked
// up in the second set with a scan of its own.
// The response register decouples the sides: a new request transaction is taken
// while the previous response still waits for rsp_ready.
`default_nettype none

module integer_set_store #(
	parameter int NUM_SETS     = 8,
	parameter int SET_CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire iss_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output iss_pkg::rsp_t      rsp
);

	localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int SLOT_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
	localparam int CNT_W  = $clog2(SET_CAPACITY + 1);
	localparam int ADDR_W = SET_W + SLOT_W;

	// Sequencer side.
	logic                       seq_idle;
	logic                       res_valid;
	logic                       res_take;
	iss_pkg::rsp_t              res;

	// Memory port.
	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic [iss_pkg::WORD_W-1:0] mem_wdata;
	logic                       mem_re;
	logic [ADDR_W-1:0]          mem_raddr;
	logic [iss_pkg::WORD_W-1:0] mem_rdata;

	// Compare unit.
	iss_pkg::match_ctl_t        mctl;
	iss_pkg::match_stat_t       mstat;
	logic [SLOT_W-1:0]          mslot;
	logic [SLOT_W-1:0]          mfree_slot;
	logic [iss_pkg::DATA_W-1:0] mkey;
	logic                       mmatch;
	logic [CNT_W-1:0]           mcount;

	// Response register.
	logic                       rsp_valid_q;
	iss_pkg::rsp_t              rsp_q;

	assign req_ready = seq_idle;

	iss_seq #(
		.NUM_SETS    (NUM_SETS),
		.SET_CAPACITY(SET_CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_valid && req_ready),
		.req       (req),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.mctl      (mctl),
		.mslot     (mslot),
		.mkey      (mkey),
		.mmatch    (mmatch),
		.mstat     (mstat),
		.mfree_slot(mfree_slot),
		.mcount    (mcount)
	);

	iss_match #(
		.SLOT_W(SLOT_W),
		.CNT_W (CNT_W)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mctl),
		.slot     (mslot),
		.key      (mkey),
		.word     (mem_rdata),
		.match    (mmatch),
		.stat     (mstat),
		.free_slot(mfree_slot),
		.count    (mcount)
	);

	iss_mem #(
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// The sequencer hands over its result as soon as the response register is free
	// or is being emptied in the same cycle.
	assign res_take = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Every accepted request takes the sequencer out of idle, so the block is never ready twice in a row
	// across an accepted transaction.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("integer_set_store: request taken while busy");

	// A set never reports more members than it has slots.
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.set_size) <= 32'(SET_CAPACITY))
		else $error("integer_set_store: set size above capacity");

	// A dropped value means the set was full, so the reported size equals SET_CAPACITY.
	a_full_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.set_size == iss_pkg::SIZE_W'(SET_CAPACITY))
		else $error("integer_set_store: overflow flagged on a set that is not full");

endmodule

`default_nettype wire
